/* rtl/core/ert_pkg.sv */
// Package for the epoch reclamation tracker.
// Holds operation, status and register codes plus default sizes.
// No dependencies; used by epoch_reclamation_tracker and its bench.
`default_nettype none

package ert_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_DELETE  = 2'd2;
    localparam logic [1:0] OP_TENANT  = 2'd3;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SLOT = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_WAIT_THR = 1'b0;
    localparam logic CFG_SLOTS    = 1'b1;

    localparam logic [3:0] WAIT_THR_RESET = 4'd4;
    localparam logic [3:0] SLOTS_RESET    = 4'd8;

    localparam int DEF_SLOTS            = 8;
    localparam int DEF_PENDING_PER_SLOT = 8;
    localparam int DEF_VERSION_BITS     = 32;
    localparam int MAX_RESULTS          = 64;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_W      = 4;

endpackage

`default_nettype wire

/* rtl/core/epoch_reclamation_tracker.sv */
// Epoch reclamation tracker: reader slots, a version counter and a pending store.
// Depends on ert_pkg and ert_ram.
//
// Usage. One word on the slave stream is one request; tuser holds the
// operation (acquire, release, delete node, tenant retire) and tdata its
// operands. Each request yields one or more result words on the master
// stream; tlast marks the final word of a request, and tuser flags a word
// that carries a retired node handle. Configuration (threshold, active slot
// count) is written on cfg_we/cfg_index/cfg_data; the user must do so only
// while no request is in work, as the block does not enforce it. Timing:
// s_axis_tready is high only while the sequencer is idle, so one request is
// worked at a time. Acquire reduces the start slot by subtraction, then
// tests one slot per cycle; delete tests one entry per cycle; a bad slot or
// a release below the threshold goes straight to the final word.
// Release and tenant retire scan the slots for the minimum pinned version,
// then per slot pass a check state, a read state for each entry and a
// compare state for each valid entry read through the store's single read
// port, and close the slot when its entries are done or the result limit
// is reached. Reset clears the counter, slot busy flags, wait counts, last
// versions and pending valid bits at once. When the receiver stalls the
// output register holds and the sequencer waits before pushing the next word.
`default_nettype none

module epoch_reclamation_tracker #(
    parameter int SLOTS            = ert_pkg::DEF_SLOTS,
    parameter int PENDING_PER_SLOT = ert_pkg::DEF_PENDING_PER_SLOT,
    parameter int VERSION_BITS     = ert_pkg::DEF_VERSION_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_slot[2:0], slot_id[5:3], node_handle[21:6], node_tenant[37:22],
    // retire_tenant[53:38], tenant_valid[54], zero fill
    input  wire logic [ert_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // status[1:0], granted_slot[4:2], retired_handle[20:5], zero fill
    output logic [ert_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // retired_valid[0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [ert_pkg::CFG_W-1:0]     cfg_data
);

    import ert_pkg::*;

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int IW    = (CW > 4) ? CW : 4;
    localparam int PW    = $clog2(PENDING_PER_SLOT + 1);
    localparam int CNTW  = (PW > 4) ? PW : 4;
    localparam int DEPTH = SLOTS * PENDING_PER_SLOT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(MAX_RESULTS + 1);
    localparam int VB    = VERSION_BITS;
    localparam int EW    = VB + 32;
    localparam logic [VB-1:0] VERSION_MAX = {VB{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MOD  = 4'd1;
    localparam logic [3:0] S_ACQ  = 4'd2;
    localparam logic [3:0] S_DEL  = 4'd3;
    localparam logic [3:0] S_MIN  = 4'd4;
    localparam logic [3:0] S_RCHK = 4'd5;
    localparam logic [3:0] S_RRD  = 4'd6;
    localparam logic [3:0] S_RCMP = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]      state_reg;
    logic [1:0]      op_reg;
    logic            tv_reg;
    logic [15:0]     tid_reg;
    logic [15:0]     handle_reg;
    logic [15:0]     ntenant_reg;
    logic [IW-1:0]   sid_reg;
    logic [IW-1:0]   cur_reg;
    logic [IW-1:0]   cnt_reg;
    logic [IW-1:0]   s_reg;
    logic [PW-1:0]   j_reg;
    logic [VB-1:0]   minv_reg;
    logic [KW-1:0]   k_reg;
    logic [1:0]      status_reg;
    logic [2:0]      granted_reg;
    logic            hold_valid_reg;
    logic [15:0]     hold_handle_reg;

    logic [VB-1:0]   gv_reg;
    logic [3:0]      thr_reg;
    logic [3:0]      nuse_reg;
    logic            busy_reg [SLOTS];
    logic [VB-1:0]   pinned_reg [SLOTS];
    logic [VB-1:0]   last_reg [SLOTS];
    logic [PW-1:0]   wcnt_reg [SLOTS];
    logic [DEPTH-1:0] pvalid_reg;

    logic                  ovalid_reg;
    logic [OUT_DATA_W-1:0] odata_reg;
    logic                  ouser_reg;
    logic                  olast_reg;

    logic [IW-1:0]   n_act;
    logic [IW-1:0]   in_sid;
    logic [SW-1:0]   sidx;
    logic [AW-1:0]   ent_addr;
    logic            j_end;
    logic            k_full;
    logic            can_push;
    logic            out_load;
    logic            ram_we;
    logic            ram_re;
    logic [EW-1:0]   ram_rdata;
    logic [VB-1:0]   ent_version;
    logic [15:0]     ent_handle;
    logic [15:0]     ent_tenant;
    logic            ent_match;
    logic            more_slots;

    always_comb
    begin
        if (nuse_reg == 4'd0)
        begin
            n_act = IW'(1);
        end
        else if (IW'(nuse_reg) > IW'(SLOTS))
        begin
            n_act = IW'(SLOTS);
        end
        else
        begin
            n_act = IW'(nuse_reg);
        end
    end

    assign in_sid     = IW'(s_axis_tdata[5:3]);
    assign sidx       = s_reg[SW-1:0];
    assign ent_addr   = AW'(int'(sidx) * PENDING_PER_SLOT + int'(j_reg));
    assign j_end      = (j_reg == PW'(PENDING_PER_SLOT));
    assign k_full     = (k_reg >= KW'(MAX_RESULTS));
    assign can_push   = !ovalid_reg || m_axis_tready;
    assign more_slots = (op_reg == OP_TENANT) && ((s_reg + IW'(1)) < n_act);

    // A new word enters the output register this cycle.
    assign out_load = ((state_reg == S_FIN) && can_push) ||
                      ((state_reg == S_RCMP) && ent_match && hold_valid_reg && can_push);

    assign ram_we = (state_reg == S_DEL) && !j_end && !pvalid_reg[ent_addr];
    assign ram_re = (state_reg == S_RRD) && !j_end && !k_full && pvalid_reg[ent_addr];

    assign ent_version = ram_rdata[VB-1:0];
    assign ent_handle  = ram_rdata[VB+15:VB];
    assign ent_tenant  = ram_rdata[VB+31:VB+16];
    assign ent_match   = (ent_version < minv_reg) || (tv_reg && (ent_tenant == tid_reg));

    ert_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_pending (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ent_addr),
        .wdata({ntenant_reg, handle_reg, gv_reg}),
        .re   (ram_re),
        .raddr(ent_addr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= WAIT_THR_RESET;
            nuse_reg <= SLOTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAIT_THR: thr_reg  <= cfg_data;
                CFG_SLOTS:    nuse_reg <= cfg_data;
                default:      thr_reg  <= thr_reg;
            endcase
        end
    end

    // Pinned versions are only read for busy slots, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ACQ && cnt_reg != n_act && !busy_reg[cur_reg[SW-1:0]])
        begin
            pinned_reg[cur_reg[SW-1:0]] <= gv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            tid_reg     <= s_axis_tdata[53:38];
            handle_reg  <= s_axis_tdata[21:6];
            ntenant_reg <= s_axis_tdata[37:22];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_ACQUIRE;
            tv_reg          <= 1'b0;
            sid_reg         <= '0;
            cur_reg         <= '0;
            cnt_reg         <= '0;
            s_reg           <= '0;
            j_reg           <= '0;
            minv_reg        <= '0;
            k_reg           <= '0;
            status_reg      <= ST_OK;
            granted_reg     <= '0;
            hold_valid_reg  <= 1'b0;
            hold_handle_reg <= '0;
            gv_reg          <= '0;
            pvalid_reg      <= '0;
            ovalid_reg      <= 1'b0;
            odata_reg       <= '0;
            ouser_reg       <= 1'b0;
            olast_reg       <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                busy_reg[i] <= 1'b0;
                last_reg[i] <= '0;
                wcnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (ovalid_reg && m_axis_tready && !out_load)
            begin
                ovalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg      <= s_axis_tuser;
                        tv_reg      <= s_axis_tdata[54] && (s_axis_tuser == OP_TENANT);
                        sid_reg     <= in_sid;
                        cur_reg     <= IW'(s_axis_tdata[2:0]);
                        cnt_reg     <= '0;
                        s_reg       <= '0;
                        j_reg       <= '0;
                        k_reg       <= '0;
                        minv_reg    <= gv_reg;
                        status_reg  <= ST_OK;
                        granted_reg <= '0;
                        unique case (s_axis_tuser)
                            OP_ACQUIRE:
                            begin
                                state_reg <= S_MOD;
                            end
                            OP_RELEASE:
                            begin
                                if (in_sid >= n_act)
                                begin
                                    status_reg <= ST_BAD_SLOT;
                                    state_reg  <= S_FIN;
                                end
                                else
                                begin
                                    busy_reg[in_sid[SW-1:0]] <= 1'b0;
                                    if (CNTW'(wcnt_reg[in_sid[SW-1:0]]) >= CNTW'(thr_reg))
                                    begin
                                        state_reg <= S_MIN;
                                    end
                                    else
                                    begin
                                        state_reg <= S_FIN;
                                    end
                                end
                            end
                            OP_DELETE:
                            begin
                                if (in_sid >= n_act)
                                begin
                                    status_reg <= ST_BAD_SLOT;
                                    state_reg  <= S_FIN;
                                end
                                else
                                begin
                                    s_reg     <= in_sid;
                                    state_reg <= S_DEL;
                                end
                            end
                            OP_TENANT:
                            begin
                                state_reg <= S_MIN;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                // Reduce the scan start below the active slot count.
                S_MOD:
                begin
                    if (cur_reg >= n_act)
                    begin
                        cur_reg <= cur_reg - n_act;
                    end
                    else
                    begin
                        state_reg <= S_ACQ;
                    end
                end

                S_ACQ:
                begin
                    if (cnt_reg == n_act)
                    begin
                        status_reg <= ST_NO_FREE;
                        state_reg  <= S_FIN;
                    end
                    else if (!busy_reg[cur_reg[SW-1:0]])
                    begin
                        busy_reg[cur_reg[SW-1:0]] <= 1'b1;
                        granted_reg <= 3'(cur_reg);
                        state_reg   <= S_FIN;
                    end
                    else
                    begin
                        cur_reg <= ((cur_reg + IW'(1)) == n_act) ? '0 : cur_reg + IW'(1);
                        cnt_reg <= cnt_reg + IW'(1);
                    end
                end

                S_DEL:
                begin
                    if (j_end)
                    begin
                        status_reg <= ST_FULL;
                        state_reg  <= S_FIN;
                    end
                    else if (!pvalid_reg[ent_addr])
                    begin
                        pvalid_reg[ent_addr] <= 1'b1;
                        wcnt_reg[sidx]       <= wcnt_reg[sidx] + PW'(1);
                        if (gv_reg != VERSION_MAX)
                        begin
                            gv_reg <= gv_reg + VB'(1);
                        end
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        j_reg <= j_reg + PW'(1);
                    end
                end

                // One slot a cycle for the minimum pinned version.
                S_MIN:
                begin
                    if (s_reg == n_act)
                    begin
                        s_reg     <= (op_reg == OP_RELEASE) ? sid_reg : '0;
                        state_reg <= S_RCHK;
                    end
                    else
                    begin
                        if (busy_reg[sidx] && pinned_reg[sidx] < minv_reg)
                        begin
                            minv_reg <= pinned_reg[sidx];
                        end
                        s_reg <= s_reg + IW'(1);
                    end
                end

                S_RCHK:
                begin
                    j_reg <= '0;
                    if ((minv_reg > last_reg[sidx] || tv_reg) && wcnt_reg[sidx] != '0)
                    begin
                        if (minv_reg > last_reg[sidx])
                        begin
                            last_reg[sidx] <= minv_reg;
                        end
                        state_reg <= S_RRD;
                    end
                    else if (more_slots)
                    begin
                        s_reg <= s_reg + IW'(1);
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end

                S_RRD:
                begin
                    if (j_end || k_full)
                    begin
                        if (more_slots)
                        begin
                            s_reg     <= s_reg + IW'(1);
                            state_reg <= S_RCHK;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                    else if (!pvalid_reg[ent_addr])
                    begin
                        j_reg <= j_reg + PW'(1);
                    end
                    else
                    begin
                        state_reg <= S_RCMP;
                    end
                end

                // A retired handle is held back one word so the final one
                // can carry tlast.
                S_RCMP:
                begin
                    if (!ent_match)
                    begin
                        j_reg     <= j_reg + PW'(1);
                        state_reg <= S_RRD;
                    end
                    else if (!hold_valid_reg || can_push)
                    begin
                        if (hold_valid_reg)
                        begin
                            ovalid_reg <= 1'b1;
                            odata_reg  <= {3'b000, hold_handle_reg, 3'b000, ST_OK};
                            ouser_reg  <= 1'b1;
                            olast_reg  <= 1'b0;
                        end
                        pvalid_reg[ent_addr] <= 1'b0;
                        wcnt_reg[sidx]       <= wcnt_reg[sidx] - PW'(1);
                        hold_valid_reg       <= 1'b1;
                        hold_handle_reg      <= ent_handle;
                        k_reg                <= k_reg + KW'(1);
                        j_reg                <= j_reg + PW'(1);
                        state_reg            <= S_RRD;
                    end
                end

                S_FIN:
                begin
                    if (can_push)
                    begin
                        ovalid_reg <= 1'b1;
                        olast_reg  <= 1'b1;
                        if (hold_valid_reg)
                        begin
                            odata_reg <= {3'b000, hold_handle_reg, 3'b000, ST_OK};
                            ouser_reg <= 1'b1;
                        end
                        else
                        begin
                            odata_reg <= {3'b000, 16'h0000, granted_reg, status_reg};
                            ouser_reg <= 1'b0;
                        end
                        hold_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;
    assign m_axis_tlast  = olast_reg;

    a_version_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> gv_reg >= $past(gv_reg))
        else $error("global version decreased");

    a_hold_only_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> state_reg != S_IDLE)
        else $error("held retired handle left behind in idle");

    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KW'(MAX_RESULTS))
        else $error("retired more nodes than the result limit");

    a_accept_idle_output: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !hold_valid_reg && k_reg == '0)
        else $error("request started with stale retirement state");

endmodule

`default_nettype wire

/* rtl/core/ert_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the pending node store of the tracker.
`default_nettype none

module ert_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
